// ===== sv/iosl_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered set list package
// Widths, operation and status codes, and the link memory write port type.
// ----------------------------------------------------------------------------
`default_nettype none

package iosl_pkg;

  // ID and link width; ID 0 means "none" in a link or a head/tail register.
  localparam int unsigned IdW   = 6;
  localparam int unsigned Depth = 1 << IdW;
  localparam logic [IdW-1:0] MaxId  = 6'd63;
  localparam logic [IdW-1:0] NoneId = '0;

  // Stream beat widths, rounded up to whole bytes for tdata.
  localparam int unsigned DataW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatW = 2;

  // Operation codes carried on the input tuser.
  localparam logic [KindW-1:0] KindAppend = 2'd0;
  localparam logic [KindW-1:0] KindRemove = 2'd1;
  localparam logic [KindW-1:0] KindDump   = 2'd2;

  // Result status codes carried on the output tuser.
  localparam logic [StatW-1:0] StRemoved = 2'd0;
  localparam logic [StatW-1:0] StFailed  = 2'd1;
  localparam logic [StatW-1:0] StEmpty   = 2'd2;
  localparam logic [StatW-1:0] StElement = 2'd3;

  // One write into a link memory.
  typedef struct packed {
    logic           en;
    logic [IdW-1:0] addr;
    logic [IdW-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

// ===== sv/iosl_ram.sv =====
// ----------------------------------------------------------------------------
// Link memory
// One write port and one read port with registered read data, one link per ID.
// ----------------------------------------------------------------------------
`default_nettype none

module iosl_ram (
  input  wire logic                   clk_i,
  input  wire iosl_pkg::ram_wr_t      wr_i,
  input  wire logic                   rd_en_i,
  input  wire logic [iosl_pkg::IdW-1:0] rd_addr_i,
  output logic      [iosl_pkg::IdW-1:0] rd_data_o
);
  import iosl_pkg::*;

  logic [IdW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/indexed_ordered_set_list_core.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered set list core
// Arrival-ordered set of unique IDs kept as a doubly linked list in two link
// memories, with a presence bit per ID and head/tail registers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata          tuser        tlast
//  s_axis    in         item_id [5:0]  kind [1:0]   -
//  m_axis    out        element_id     status [1:0] last result of the operation
//
//  An append holds the input through S_APP1 and S_APP2, a remove through S_RM1,
//  S_RM2 and S_RES, a failed remove or an empty dump through S_RES, and a dump
//  through S_DREAD and S_DEMIT per listed element, as each walk step waits on
//  the registered next-link read. Reset clears the presence bits, head and tail
//  at once; links need no clearing. The input is not ready while an operation
//  is in progress, and a full output register holds the result and the walk.
`default_nettype none

module indexed_ordered_set_list_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [iosl_pkg::DataW-1:0]  s_axis_tdata,   // [5:0] item_id
  input  wire logic [iosl_pkg::KindW-1:0]  s_axis_tuser,   // [1:0] kind
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [iosl_pkg::DataW-1:0]  m_axis_tdata,   // [5:0] element_id
  output logic      [iosl_pkg::StatW-1:0]  m_axis_tuser,   // [1:0] status
  output logic                             m_axis_tlast    // last
);
  import iosl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP1,
    S_APP2,
    S_RM1,
    S_RM2,
    S_RES,
    S_DREAD,
    S_DEMIT
  } state_e;

  state_e           state_q;
  logic [Depth-1:0] present_q;
  logic [IdW-1:0]   head_q;
  logic [IdW-1:0]   tail_q;
  logic [IdW-1:0]   id_q;
  logic [IdW-1:0]   count_q;
  logic [StatW-1:0] res_q;

  logic [IdW-1:0] in_id;
  logic           in_valid_id;
  logic           accept;
  logic           out_free;
  logic           emit;
  logic           walk_last;

  ram_wr_t        next_wr;
  ram_wr_t        prev_wr;
  logic           next_rd_en;
  logic [IdW-1:0] next_rd_addr;
  logic           prev_rd_en;
  logic [IdW-1:0] next_rd_data;
  logic [IdW-1:0] prev_rd_data;

  assign in_id         = s_axis_tdata[IdW-1:0];
  assign in_valid_id   = (in_id != NoneId) && (in_id <= MaxId);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = out_free && ((state_q == S_RES) || (state_q == S_DEMIT));
  assign walk_last     = (next_rd_data == NoneId) || (count_q == MaxId - 6'd1);

  // Link memory port control per sequencer step.
  always_comb begin
    next_wr      = '0;
    prev_wr      = '0;
    next_rd_en   = 1'b0;
    next_rd_addr = id_q;
    prev_rd_en   = 1'b0;
    unique case (state_q)
      S_APP1: begin
        next_wr = '{en: 1'b1, addr: id_q, data: NoneId};
        prev_wr = '{en: 1'b1, addr: id_q, data: tail_q};
      end
      S_APP2: begin
        next_wr = '{en: (tail_q != NoneId), addr: tail_q, data: id_q};
      end
      S_RM1: begin
        next_rd_en = 1'b1;
        prev_rd_en = 1'b1;
      end
      S_RM2: begin
        next_wr = '{en: (prev_rd_data != NoneId), addr: prev_rd_data, data: next_rd_data};
        prev_wr = '{en: (next_rd_data != NoneId), addr: next_rd_data, data: prev_rd_data};
      end
      S_DREAD: begin
        next_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  iosl_ram u_next_ram (
    .clk_i     (clk_i),
    .wr_i      (next_wr),
    .rd_en_i   (next_rd_en),
    .rd_addr_i (next_rd_addr),
    .rd_data_o (next_rd_data)
  );

  iosl_ram u_prev_ram (
    .clk_i     (clk_i),
    .wr_i      (prev_wr),
    .rd_en_i   (prev_rd_en),
    .rd_addr_i (id_q),
    .rd_data_o (prev_rd_data)
  );

  // Sequencer, list registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      present_q     <= '0;
      head_q        <= NoneId;
      tail_q        <= NoneId;
      id_q          <= NoneId;
      count_q       <= '0;
      res_q         <= StRemoved;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= StRemoved;
      m_axis_tlast  <= 1'b0;
    end else begin
      // The output register fills on a new result and empties when taken.
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (s_axis_tuser)
              KindAppend: begin
                id_q <= in_id;
                if (in_valid_id && !present_q[in_id]) begin
                  state_q <= S_APP1;
                end
              end
              KindRemove: begin
                id_q <= in_id;
                if (in_valid_id && present_q[in_id]) begin
                  state_q <= S_RM1;
                end else begin
                  res_q   <= StFailed;
                  state_q <= S_RES;
                end
              end
              KindDump: begin
                if (head_q == NoneId) begin
                  res_q   <= StEmpty;
                  state_q <= S_RES;
                end else begin
                  id_q    <= head_q;
                  count_q <= '0;
                  state_q <= S_DREAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_APP1: begin
          state_q <= S_APP2;
        end
        S_APP2: begin
          if (tail_q == NoneId) begin
            head_q <= id_q;
          end
          tail_q          <= id_q;
          present_q[id_q] <= 1'b1;
          state_q         <= S_IDLE;
        end
        S_RM1: begin
          state_q <= S_RM2;
        end
        S_RM2: begin
          if (prev_rd_data == NoneId) begin
            head_q <= next_rd_data;
          end
          if (next_rd_data == NoneId) begin
            tail_q <= prev_rd_data;
          end
          present_q[id_q] <= 1'b0;
          res_q           <= StRemoved;
          state_q         <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            m_axis_tdata  <= '0;
            m_axis_tuser  <= res_q;
            m_axis_tlast  <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        S_DREAD: begin
          state_q <= S_DEMIT;
        end
        S_DEMIT: begin
          if (out_free) begin
            m_axis_tdata  <= {{(DataW-IdW){1'b0}}, id_q};
            m_axis_tuser  <= StElement;
            m_axis_tlast  <= walk_last;
            id_q          <= next_rd_data;
            count_q       <= count_q + 6'd1;
            state_q       <= walk_last ? S_IDLE : S_DREAD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
